### design/atilt_pkg.sv
// Shared types, constants and helper functions of the accelerometer tilt estimator.
// Has no dependencies. Every other design file but atilt_chk imports it.
`default_nettype none

package atilt_pkg;

    // Defaults for the top-level parameters.
    localparam int TAP_COUNT_DEF     = 10;
    localparam int WINDOW_LENGTH_DEF = 5;
    localparam int CORDIC_STEPS_DEF  = 16;

    // Each square-root iteration produces one result bit, and the result has 32 bits.
    localparam int SQRT_STEPS = 32;

    localparam int AXIS_W  = 16;
    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int ACC_W   = 40;   // FIR accumulator, wide enough for 32 taps
    localparam int CX_W    = 36;   // CORDIC vector components
    localparam int CZ_W    = 34;   // CORDIC angle, in 0.01 degree / 65536
    localparam int SUM_W   = 21;   // window sum of up to 16 angles
    localparam int COEF_W  = 13;

    localparam int ROLL_LIM  = 18000;
    localparam int PITCH_LIM = 9000;

    localparam logic [COEF_W-1:0] HALF_COEF [5] = '{
        13'd393, 13'd1068, 13'd2910, 13'd5211, 13'd6802
    };

    // round(atan(2^-i) in degrees * 100 * 65536)
    localparam logic signed [CZ_W-1:0] ATAN_UNITS [24] = '{
        34'sd294912000, 34'sd174096719, 34'sd91987925, 34'sd46694507,
        34'sd23437865,  34'sd11730358,  34'sd5866610,  34'sd2933484,
        34'sd1466764,   34'sd733385,    34'sd366693,   34'sd183346,
        34'sd91673,     34'sd45837,     34'sd22918,    34'sd11459,
        34'sd5730,      34'sd2865,      34'sd1432,     34'sd716,
        34'sd358,       34'sd179,       34'sd90,       34'sd45
    };

    typedef enum logic [3:0] {
        S_IDLE, S_FIR, S_RND, S_SQ, S_ADD, S_ROOT, S_PSTART, S_PITCH,
        S_PDONE, S_MEAN, S_DIV, S_OUT
    } t_state;

    typedef struct packed {
        logic restart;
        logic load;
        logic fir_mac;
        logic fir_round;
        logic square;
        logic root_start;
        logic root_step;
        logic cor_step;
        logic pitch_start;
        logic pitch_done;
        logic mean_acc;
        logic mean_div;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_pending;
        logic out_taken;
    } t_dp_status;

    // Coefficient of tap k: the taps mirror about the center, and the
    // table ends at its fifth entry.
    function automatic logic [COEF_W-1:0] f_coef(input int k, input int taps);
        int j;
        j = k;
        if (taps - 1 - k < j) j = taps - 1 - k;
        if (j > 4) j = 4;
        if (j < 0) j = 0;
        return HALF_COEF[j];
    endfunction

    function automatic logic signed [AXIS_W-1:0] f_sat16(
        input logic signed [ACC_W-16:0] v);
        if (v > 25'sd32767) return 16'sh7fff;
        if (v < -25'sd32768) return 16'sh8000;
        return v[AXIS_W-1:0];
    endfunction

    // Round the angle to 0.01 degree and clamp it to +/- lim.
    function automatic logic signed [ROLL_W-1:0] f_angle(
        input logic signed [CZ_W-1:0] z, input int lim);
        logic signed [CZ_W:0]   r;
        logic signed [CZ_W-16:0] q;
        r = {z[CZ_W-1], z} + 35'sd32768;
        q = r[CZ_W:16];
        if (q > 19'(lim)) return 16'(lim);
        if (q < -19'(lim)) return 16'(-lim);
        return q[ROLL_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/accel_tilt_estimator_unit.sv
// Top level of the accelerometer tilt estimator: stream ports, sequencer and datapath.
// Depends on atilt_pkg, atilt_ctrl and atilt_dp.
`default_nettype none

// Each sample request carries three signed 16-bit accelerometer axes. Every axis is
// smoothed by its own symmetric low-pass FIR (Q1.15 coefficients, rounded and saturated
// to 16 bits), then roll = atan2(y, z) and pitch = atan2(-x, sqrt(y^2 + z^2)) are found
// by CORDIC vectoring in units of 0.01 degree, and both enter a ring of WINDOW_LENGTH
// entries whose rounded means are reported once the ring has filled (the last means are
// held before that, and mean_valid shows the ring state). A request with tuser set is a
// restart: it clears the FIR lines, the ring position and the full flag at once, keeps
// the ring contents and held means, and produces no result. The block works on one
// sample at a time. From acceptance to its result entering the output register, a sample
// passes through the three FIR multiply-accumulate lanes (one per axis, sharing the tap
// index), the rounding, the squares, the bit-serial square root (the roll rotation runs
// alongside it), the pitch CORDIC iterations, the sums over the ring entries and the
// mean division. A restart request completes in the cycle it is accepted. The output
// register holds a result until it is taken, while the next sample is already accepted
// and processed.
module accel_tilt_estimator_unit #(
    parameter int TAP_COUNT     = atilt_pkg::TAP_COUNT_DEF,
    parameter int WINDOW_LENGTH = atilt_pkg::WINDOW_LENGTH_DEF,
    parameter int CORDIC_STEPS  = atilt_pkg::CORDIC_STEPS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    input  wire  [47:0]  s_axis_tdata,
    // [0] action (1 = restart)
    input  wire          s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [15:0] filtered_x, [31:16] filtered_y, [47:32] filtered_z, [63:48] roll_now,
    // [78:64] pitch_now, [94:79] roll_mean, [109:95] pitch_mean, [111:110] zero
    output logic [111:0] m_axis_tdata,
    // [0] mean_valid
    output logic         m_axis_tuser
);
    import atilt_pkg::*;

    // The step counter covers the longer of the FIR and square-root phases.
    localparam int MAX_STEPS = (TAP_COUNT > SQRT_STEPS) ? TAP_COUNT : SQRT_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    t_dp_cmd              cmd;
    t_dp_status           status;
    logic [CNT_W-1:0]     idx;
    logic signed [15:0]   fx, fy, fz, roll_now, roll_mean;
    logic signed [14:0]   pitch_now, pitch_mean;
    logic                 mean_valid;

    atilt_ctrl #(
        .TAP_COUNT    (TAP_COUNT),
        .WINDOW_LENGTH(WINDOW_LENGTH),
        .CORDIC_STEPS (CORDIC_STEPS),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_action(s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_status(status),
        .o_cmd   (cmd),
        .o_idx   (idx)
    );

    atilt_dp #(
        .TAP_COUNT    (TAP_COUNT),
        .WINDOW_LENGTH(WINDOW_LENGTH),
        .CORDIC_STEPS (CORDIC_STEPS),
        .CNT_W        (CNT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_accel_x   (s_axis_tdata[15:0]),
        .i_accel_y   (s_axis_tdata[31:16]),
        .i_accel_z   (s_axis_tdata[47:32]),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_filtered_x(fx),
        .o_filtered_y(fy),
        .o_filtered_z(fz),
        .o_roll_now  (roll_now),
        .o_pitch_now (pitch_now),
        .o_roll_mean (roll_mean),
        .o_pitch_mean(pitch_mean),
        .o_mean_valid(mean_valid)
    );

    assign m_axis_tdata = {2'd0, pitch_mean, roll_mean, pitch_now, roll_now, fz, fy, fx};
    assign m_axis_tuser = mean_valid;

endmodule

`default_nettype wire

### design/atilt_ctrl.sv
// Sequencer of the accelerometer tilt estimator: a state machine and its step counter.
// Depends on atilt_pkg and drives the command struct of atilt_dp.
`default_nettype none

module atilt_ctrl #(
    parameter int TAP_COUNT     = atilt_pkg::TAP_COUNT_DEF,
    parameter int WINDOW_LENGTH = atilt_pkg::WINDOW_LENGTH_DEF,
    parameter int CORDIC_STEPS  = atilt_pkg::CORDIC_STEPS_DEF,
    parameter int CNT_W         = 5
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire                   i_action,
    output logic                  o_ready,
    input  atilt_pkg::t_dp_status i_status,
    output atilt_pkg::t_dp_cmd    o_cmd,
    output logic [CNT_W-1:0]      o_idx
);
    import atilt_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_cnt   = '0;
                if (i_valid) begin
                    if (i_action) begin
                        o_cmd.restart = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_FIR;
                    end
                end
            end
            S_FIR: begin
                o_cmd.fir_mac = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TAP_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.fir_round = 1'b1;
                n_state         = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_cmd.root_start = 1'b1;
                n_state          = S_ROOT;
            end
            S_ROOT: begin
                // The roll rotation runs beside the square root.
                o_cmd.root_step = 1'b1;
                o_cmd.cor_step  = (r_cnt < CNT_W'(CORDIC_STEPS));
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_PSTART;
                end
            end
            S_PSTART: begin
                o_cmd.pitch_start = 1'b1;
                n_state           = S_PITCH;
            end
            S_PITCH: begin
                o_cmd.cor_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_PDONE;
                end
            end
            S_PDONE: begin
                o_cmd.pitch_done = 1'b1;
                n_state          = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.mean_acc = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WINDOW_LENGTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.mean_div = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_pending || i_status.out_taken) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idx = r_cnt;

endmodule

`default_nettype wire

### design/atilt_dp.sv
// Datapath of the accelerometer tilt estimator: FIR lines and MACs, square root,
// CORDIC, averaging window and the output register. Depends on atilt_pkg.
`default_nettype none

module atilt_dp #(
    parameter int TAP_COUNT     = atilt_pkg::TAP_COUNT_DEF,
    parameter int WINDOW_LENGTH = atilt_pkg::WINDOW_LENGTH_DEF,
    parameter int CORDIC_STEPS  = atilt_pkg::CORDIC_STEPS_DEF,
    parameter int CNT_W         = 5
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  atilt_pkg::t_dp_cmd                   i_cmd,
    input  wire [CNT_W-1:0]                      i_idx,
    input  wire signed [atilt_pkg::AXIS_W-1:0]   i_accel_x,
    input  wire signed [atilt_pkg::AXIS_W-1:0]   i_accel_y,
    input  wire signed [atilt_pkg::AXIS_W-1:0]   i_accel_z,
    input  wire                                  i_out_ready,
    output atilt_pkg::t_dp_status                o_status,
    output logic                                 o_out_valid,
    output logic signed [atilt_pkg::AXIS_W-1:0]  o_filtered_x,
    output logic signed [atilt_pkg::AXIS_W-1:0]  o_filtered_y,
    output logic signed [atilt_pkg::AXIS_W-1:0]  o_filtered_z,
    output logic signed [atilt_pkg::ROLL_W-1:0]  o_roll_now,
    output logic signed [atilt_pkg::PITCH_W-1:0] o_pitch_now,
    output logic signed [atilt_pkg::ROLL_W-1:0]  o_roll_mean,
    output logic signed [atilt_pkg::PITCH_W-1:0] o_pitch_mean,
    output logic                                 o_mean_valid
);
    import atilt_pkg::*;

    localparam int TIW     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int WIW     = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int RECIP_K = 26;
    localparam int RECIP_W = 28;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_K) / WINDOW_LENGTH + 1);
    localparam logic signed [CZ_W-1:0] Z_QUARTER = 34'sd589824000;

    // FIR delay lines; entry 0 holds the newest sample.
    logic signed [AXIS_W-1:0] r_line_x [TAP_COUNT];
    logic signed [AXIS_W-1:0] r_line_y [TAP_COUNT];
    logic signed [AXIS_W-1:0] r_line_z [TAP_COUNT];
    logic signed [ACC_W-1:0]  r_acc_x, r_acc_y, r_acc_z;
    logic signed [AXIS_W-1:0] r_fx, r_fy, r_fz;

    logic [TIW-1:0]            tap;
    logic signed [COEF_W:0]    coef;
    logic signed [ACC_W-1:0]   prod_x, prod_y, prod_z, rnd_x, rnd_y, rnd_z;

    assign tap    = i_idx[TIW-1:0];
    assign coef   = $signed({1'b0, f_coef(int'(tap), TAP_COUNT)});
    assign prod_x = ACC_W'(coef * r_line_x[tap]);
    assign prod_y = ACC_W'(coef * r_line_y[tap]);
    assign prod_z = ACC_W'(coef * r_line_z[tap]);
    assign rnd_x  = r_acc_x + 40'sd16384;
    assign rnd_y  = r_acc_y + 40'sd16384;
    assign rnd_z  = r_acc_z + 40'sd16384;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                r_line_x[k] <= '0;
                r_line_y[k] <= '0;
                r_line_z[k] <= '0;
            end
        end else if (i_cmd.load) begin
            for (int k = TAP_COUNT - 1; k > 0; k--) begin
                r_line_x[k] <= r_line_x[k-1];
                r_line_y[k] <= r_line_y[k-1];
                r_line_z[k] <= r_line_z[k-1];
            end
            r_line_x[0] <= i_accel_x;
            r_line_y[0] <= i_accel_y;
            r_line_z[0] <= i_accel_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (i_cmd.fir_mac) begin
            r_acc_x <= r_acc_x + prod_x;
            r_acc_y <= r_acc_y + prod_y;
            r_acc_z <= r_acc_z + prod_z;
        end
        if (i_cmd.fir_round) begin
            r_fx <= f_sat16(rnd_x[ACC_W-1:15]);
            r_fy <= f_sat16(rnd_y[ACC_W-1:15]);
            r_fz <= f_sat16(rnd_z[ACC_W-1:15]);
        end
    end

    // Magnitude: squares, then a bit-pair-per-cycle square root of sum * 2^32.
    logic signed [2*AXIS_W-1:0] r_sq_y, r_sq_z;
    logic [63:0]                r_rad;
    logic [34:0]                r_rem;
    logic [31:0]                r_root;
    logic [34:0]                rem_sh, trial;
    logic [2*AXIS_W-1:0]        sq_sum;

    assign sq_sum = 32'(r_sq_y) + 32'(r_sq_z);
    assign rem_sh = {r_rem[32:0], r_rad[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq_y <= r_fy * r_fy;
            r_sq_z <= r_fz * r_fz;
        end
        if (i_cmd.root_start) begin
            r_rad  <= {sq_sum, 32'd0};
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    // Shared CORDIC in vectoring mode, first for roll and then for pitch.
    logic signed [CX_W-1:0] r_cx, r_cy, ld_x, ld_y, dx, dy;
    logic signed [CZ_W-1:0] r_cz;
    logic                   r_czero;
    logic signed [ROLL_W-1:0] r_roll, ang_roll, ang_pitch;

    always_comb begin
        if (i_cmd.pitch_start) begin
            ld_x = CX_W'({4'd0, r_root});
            ld_y = -(CX_W'(r_fx) <<< 16);
        end else begin
            ld_x = CX_W'(r_fz) <<< 16;
            ld_y = CX_W'(r_fy) <<< 16;
        end
    end

    assign dx        = r_cy >>> i_idx;
    assign dy        = r_cx >>> i_idx;
    assign ang_roll  = r_czero ? '0 : f_angle(r_cz, ROLL_LIM);
    assign ang_pitch = r_czero ? '0 : f_angle(r_cz, PITCH_LIM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_start || i_cmd.pitch_start) begin
            r_czero <= (ld_x == '0) && (ld_y == '0);
            if (ld_x < 0) begin
                if (ld_y >= 0) begin
                    r_cx <= ld_y;
                    r_cy <= -ld_x;
                    r_cz <= Z_QUARTER;
                end else begin
                    r_cx <= -ld_y;
                    r_cy <= ld_x;
                    r_cz <= -Z_QUARTER;
                end
            end else begin
                r_cx <= ld_x;
                r_cy <= ld_y;
                r_cz <= '0;
            end
        end else if (i_cmd.cor_step) begin
            // A y of exactly zero rotates in the negative direction.
            if (r_cy > 0) begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + ATAN_UNITS[i_idx[4:0]];
            end else begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - ATAN_UNITS[i_idx[4:0]];
            end
        end
        if (i_cmd.pitch_start) begin
            r_roll <= ang_roll;
        end
    end

    // Averaging window.
    logic signed [ROLL_W-1:0]  r_roll_win  [WINDOW_LENGTH];
    logic signed [PITCH_W-1:0] r_pitch_win [WINDOW_LENGTH];
    logic [WIW-1:0]            r_widx;
    logic                      r_full;
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [SUM_W-1:0]   r_sum_r, r_sum_p;
    logic signed [ROLL_W-1:0]  r_hold_r;
    logic signed [PITCH_W-1:0] r_hold_p;
    logic [WIW:0]              widx_inc;
    logic [WIW-1:0]            ridx;
    logic [SUM_W-1:0]          abs_r, abs_p;
    logic [SUM_W+RECIP_W-1:0]  quo_r, quo_p;
    logic signed [SUM_W-1:0]   mean_r, mean_p;

    assign widx_inc = {1'b0, r_widx} + 1'b1;
    assign ridx     = i_idx[WIW-1:0];
    assign abs_r    = (r_sum_r < 0 ? SUM_W'(-r_sum_r) : SUM_W'(r_sum_r))
                      + SUM_W'(WINDOW_LENGTH / 2);
    assign abs_p    = (r_sum_p < 0 ? SUM_W'(-r_sum_p) : SUM_W'(r_sum_p))
                      + SUM_W'(WINDOW_LENGTH / 2);
    assign quo_r    = (abs_r * RECIP) >> RECIP_K;
    assign quo_p    = (abs_p * RECIP) >> RECIP_K;
    assign mean_r   = r_sum_r < 0 ? -SUM_W'(quo_r) : SUM_W'(quo_r);
    assign mean_p   = r_sum_p < 0 ? -SUM_W'(quo_p) : SUM_W'(quo_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
                r_roll_win[k]  <= '0;
                r_pitch_win[k] <= '0;
            end
            r_widx   <= '0;
            r_full   <= 1'b0;
            r_hold_r <= '0;
            r_hold_p <= '0;
        end else begin
            if (i_cmd.restart) begin
                r_widx <= '0;
                r_full <= 1'b0;
            end else if (i_cmd.pitch_done) begin
                r_roll_win[r_widx]  <= r_roll;
                r_pitch_win[r_widx] <= ang_pitch[PITCH_W-1:0];
                if (widx_inc == (WIW+1)'(WINDOW_LENGTH)) begin
                    r_widx <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_widx <= widx_inc[WIW-1:0];
                end
            end
            if (i_cmd.mean_div && r_full) begin
                r_hold_r <= mean_r[ROLL_W-1:0];
                r_hold_p <= mean_p[PITCH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pitch_done) begin
            r_pitch <= ang_pitch[PITCH_W-1:0];
            r_sum_r <= '0;
            r_sum_p <= '0;
        end else if (i_cmd.mean_acc) begin
            r_sum_r <= r_sum_r + SUM_W'(r_roll_win[ridx]);
            r_sum_p <= r_sum_p + SUM_W'(r_pitch_win[ridx]);
        end
    end

    // Output register; it holds a result while the next sample is worked on.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_filtered_x <= r_fx;
            o_filtered_y <= r_fy;
            o_filtered_z <= r_fz;
            o_roll_now   <= r_roll;
            o_pitch_now  <= r_pitch;
            o_roll_mean  <= r_hold_r;
            o_pitch_mean <= r_hold_p;
            o_mean_valid <= r_full;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status.out_pending = r_out_valid;
    assign o_status.out_taken   = i_out_ready;

endmodule

`default_nettype wire

### design/atilt_chk.sv
// Port-level checker of the accelerometer tilt estimator and its bind statement.
// Depends on accel_tilt_estimator_unit.
`default_nettype none

module atilt_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire         s_axis_tuser,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [111:0] m_axis_tdata
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A sample request starts work, so no request is taken in the next cycle.
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
        else $error("request taken while a sample is in work");

    // A restart finishes at once and the block stays ready.
    a_restart_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready)
        else $error("restart did not complete in one cycle");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Roll stays within half a turn.
    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[63:48]) <= 16'sd18000)
                       && ($signed(m_axis_tdata[63:48]) >= -16'sd18000))
        else $error("roll out of range");

endmodule

bind accel_tilt_estimator_unit atilt_chk u_atilt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

### bench/tb_top.sv
// Testbench for accel_tilt_estimator_unit: directed table of requests, then random
// streams, each result checked against a behavioral tilt predictor. Depends on atilt_pkg and accel_tilt_estimator_unit.
`default_nettype none

module tb_top;

    import atilt_pkg::*;

    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_RESTART = 1'b1;
    localparam int   TAPS = 10;
    localparam int   WIN  = 5;
    localparam int   STEPS = 16;
    localparam int   N_RANDOM = 1600;

    // One result of the block, unpacked.
    typedef struct packed {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] roll_avg;
        logic signed [14:0] pitch_avg;
        logic               avg_ok;
    } t_tilt;

    // One row of the directed table; has_want marks a typed-in result.
    typedef struct {
        logic               act;
        logic signed [15:0] ax, ay, az;
        bit                 has_want;
        t_tilt              want;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tuser;

    accel_tilt_estimator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Predictor state: filter histories, angle ring and held means.
    longint hist_x [TAPS-1];
    longint hist_y [TAPS-1];
    longint hist_z [TAPS-1];
    longint ring_roll [WIN];
    longint ring_pitch [WIN];
    int     ring_pos;
    bit     ring_full;
    longint mean_roll, mean_pitch;

    t_tilt  pending_tilt [$];
    int     errors;
    int     n_results;
    int     n_restarts;

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint lowpass(ref longint h [TAPS-1], input longint smp);
        longint acc, v;
        int     j;
        acc = 0;
        for (int k = 0; k < TAPS; k++) begin
            j = (TAPS - 1 - k < k) ? TAPS - 1 - k : k;
            if (j > 4) j = 4;
            v = (k == 0) ? smp : h[k-1];
            acc += longint'(HALF_COEF[j]) * v;
        end
        for (int k = TAPS - 2; k > 0; k--) h[k] = h[k-1];
        h[0] = smp;
        acc = floor_shift(acc + 16384, 15);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return acc;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Vectoring CORDIC; a y of exactly zero rotates the negative way.
    function automatic longint vector_angle(longint xc, longint yc);
        longint z, t, dx, dy;
        z = 0;
        if (xc == 0 && yc == 0) return 0;
        if (xc < 0) begin
            t = xc;
            if (yc >= 0) begin
                xc = yc; yc = -t; z = 2 * longint'(ATAN_UNITS[0]);
            end else begin
                xc = -yc; yc = t; z = -2 * longint'(ATAN_UNITS[0]);
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = floor_shift(yc, i);
            dy = floor_shift(xc, i);
            if (yc > 0) begin
                xc += dx; yc -= dy; z += longint'(ATAN_UNITS[i]);
            end else begin
                xc -= dx; yc += dy; z -= longint'(ATAN_UNITS[i]);
            end
        end
        return floor_shift(z + 32768, 16);
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint ring_avg(longint w [WIN]);
        longint s;
        s = 0;
        foreach (w[k]) s += w[k];
        if (s >= 0) return (s + WIN / 2) / WIN;
        return -((-s + WIN / 2) / WIN);
    endfunction

    // Advances the predictor by one accepted request and queues any result.
    task automatic predict_tilt(input logic act, input logic signed [15:0] ax,
                                input logic signed [15:0] ay, input logic signed [15:0] az);
        longint fx, fy, fz, r, p, mag;
        t_tilt  t;
        if (act == ACT_RESTART) begin
            foreach (hist_x[k]) begin
                hist_x[k] = 0; hist_y[k] = 0; hist_z[k] = 0;
            end
            ring_pos = 0;
            ring_full = 0;
            n_restarts++;
            return;
        end
        fx = lowpass(hist_x, ax);
        fy = lowpass(hist_y, ay);
        fz = lowpass(hist_z, az);
        r = clip(vector_angle(fz * 65536, fy * 65536), ROLL_LIM);
        mag = int_sqrt(longint'(fy * fy + fz * fz) << 32);
        p = clip(vector_angle(mag, -fx * 65536), PITCH_LIM);
        ring_roll[ring_pos] = r;
        ring_pitch[ring_pos] = p;
        ring_pos++;
        if (ring_pos >= WIN) begin
            ring_pos = 0;
            ring_full = 1;
        end
        if (ring_full) begin
            mean_roll = ring_avg(ring_roll);
            mean_pitch = ring_avg(ring_pitch);
        end
        t.fx = fx[15:0]; t.fy = fy[15:0]; t.fz = fz[15:0];
        t.roll = r[15:0]; t.pitch = p[14:0];
        t.roll_avg = mean_roll[15:0]; t.pitch_avg = mean_pitch[14:0];
        t.avg_ok = ring_full;
        pending_tilt.push_back(t);
    endtask

    // Predictor follows the request port.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_tilt(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                         s_axis_tdata[47:32]);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_tilt got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.fx = m_axis_tdata[15:0];
            got.fy = m_axis_tdata[31:16];
            got.fz = m_axis_tdata[47:32];
            got.roll = m_axis_tdata[63:48];
            got.pitch = m_axis_tdata[78:64];
            got.roll_avg = m_axis_tdata[94:79];
            got.pitch_avg = m_axis_tdata[109:95];
            got.avg_ok = m_axis_tuser;
            n_results++;
            if (pending_tilt.size() == 0) begin
                $display("%0t: result with nothing expected, actual %p", $time, got);
                errors++;
            end else begin
                want = pending_tilt.pop_front();
                if (got !== want || m_axis_tdata[111:110] !== '0) begin
                    $display("%0t: mismatch, expected %p actual %p pad %h", $time,
                             want, got, m_axis_tdata[111:110]);
                    errors++;
                end
            end
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    // Result-side backpressure, with quiet stretches.
    initial begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    end

    // Sends one request and waits for it to be taken.
    task automatic send_req(input logic act, input logic [15:0] ax,
                            input logic [15:0] ay, input logic [15:0] az);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {az, ay, ax};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Random axis value, biased toward extremes and small values.
    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    t_row plan [$];

    task automatic add_row(input logic act, input logic [15:0] ax,
                           input logic [15:0] ay, input logic [15:0] az);
        t_row r;
        r.act = act; r.ax = ax; r.ay = ay; r.az = az; r.has_want = 0;
        plan.push_back(r);
    endtask

    initial begin
        t_row  r;
        int    run;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        errors = 0; n_results = 0; n_restarts = 0;
        foreach (hist_x[k]) begin
            hist_x[k] = 0; hist_y[k] = 0; hist_z[k] = 0;
        end
        foreach (ring_roll[k]) begin
            ring_roll[k] = 0; ring_pitch[k] = 0;
        end
        ring_pos = 0; ring_full = 0; mean_roll = 0; mean_pitch = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All-zero sample after reset: every field zero, including atan2(0,0).
        r.act = ACT_SAMPLE; r.ax = 0; r.ay = 0; r.az = 0;
        r.has_want = 1; r.want = '0;
        plan.push_back(r);
        // Extremes: full positive and full negative steps on the axes.
        add_row(ACT_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff);
        add_row(ACT_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff);
        add_row(ACT_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
        add_row(ACT_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
        add_row(ACT_SAMPLE, 16'h8000, 16'h0000, 16'h8000);
        add_row(ACT_RESTART, 16'hffff, 16'hffff, 16'hffff);
        // Negative z with y of each sign hits the quadrant pre-rotation.
        add_row(ACT_SAMPLE, 16'h0000, 16'h4000, 16'hc000);
        add_row(ACT_SAMPLE, 16'h0000, 16'hc000, 16'hc000);
        add_row(ACT_SAMPLE, 16'h7fff, 16'h0000, 16'h0000);
        add_row(ACT_SAMPLE, 16'h0000, 16'h0000, 16'h8000);
        add_row(ACT_SAMPLE, 16'h0000, 16'h7fff, 16'h0000);
        add_row(ACT_SAMPLE, 16'h0001, 16'hffff, 16'h0001);
        add_row(ACT_SAMPLE, 16'h1234, 16'hedcb, 16'h5555);
        add_row(ACT_RESTART, 16'h0000, 16'h0000, 16'h0000);
        add_row(ACT_RESTART, 16'h0000, 16'h0000, 16'h0000);
        add_row(ACT_SAMPLE, 16'haaaa, 16'h5555, 16'h0f0f);
        for (int k = 0; k < 6; k++) add_row(ACT_SAMPLE, 16'h8000, 16'h7fff, 16'h8000);

        foreach (plan[i]) begin
            r = plan[i];
            if (r.has_want) begin
                wait (pending_tilt.size() == 0);
                @(posedge i_clk);
            end
            send_req(r.act, r.ax, r.ay, r.az);
            if (r.has_want) begin
                // The predictor queues this row's result in the same time step.
                wait (pending_tilt.size() > 0);
                if (pending_tilt[$] !== r.want) begin
                    $display("%0t: table row %0d expected %p predicted %p", $time, i,
                             r.want, pending_tilt[$]);
                    errors++;
                end
            end
        end

        // Random part: sample runs of varied length, each closed by a restart,
        // most of them long enough that the window fills and wraps.
        for (int n = 0; n < N_RANDOM; ) begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 30);
            for (int k = 0; k < run && n < N_RANDOM; k++, n++)
                send_req(ACT_SAMPLE, rand_axis(), rand_axis(), rand_axis());
            send_req(ACT_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_tilt.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d results and %0d restarts, axis extremes, all quadrants,",
                 n_results, n_restarts);
        $display("window fill and wrap with random backpressure on both ports.");
        if (errors == 0 && pending_tilt.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog: the directed table and N_RANDOM random samples with their restarts, plus long stalls on both sides.
    initial begin
        #20000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
